FILE: rtl/core/slmu_pkg.sv
// Package for the sorted list merge union block.
// Holds the default sizes that the top level and the channel interfaces share.
// No dependencies.
`timescale 1ns / 1ps

package slmu_pkg;

	// Default number of entries in each list store.
	localparam int DEF_LIST_DEPTH = 16;

	// Default width of a list element and of a union value.
	localparam int DEF_VALUE_WIDTH = 32;

endpackage

FILE: rtl/core/slmu_elem_if.sv
// Element input channel of the sorted list merge union block.
// Carries valid, ready and one list element per request.
// Depends on slmu_pkg.
`timescale 1ns / 1ps

interface slmu_elem_if #(
	parameter int VALUE_WIDTH = slmu_pkg::DEF_VALUE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic                          list_select;
	logic signed [VALUE_WIDTH-1:0] element_value;
	logic                          end_of_list;

	modport source (
		output valid, list_select, element_value, end_of_list,
		input  ready
	);

	modport sink (
		input  valid, list_select, element_value, end_of_list,
		output ready
	);
endinterface

FILE: rtl/core/slmu_union_if.sv
// Result output channel of the sorted list merge union block.
// Carries valid, ready and one union value per request.
// Depends on slmu_pkg.
`timescale 1ns / 1ps

interface slmu_union_if #(
	parameter int VALUE_WIDTH = slmu_pkg::DEF_VALUE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] union_value;
	logic                          union_last;
	logic                          overflow_seen;

	modport source (
		output valid, union_value, union_last, overflow_seen,
		input  ready
	);

	modport sink (
		input  valid, union_value, union_last, overflow_seen,
		output ready
	);
endinterface

FILE: rtl/core/sorted_list_merge_union_top.sv
// Top level of the sorted list merge union block: two list memories and the merge sequencer.
// Depends on slmu_pkg, slmu_elem_if and slmu_union_if.
`timescale 1ns / 1ps

// Usage
// The elem channel takes list elements, one request per cycle while the block is loading.
// list_select picks the first (0) or second (1) list; each list must arrive in ascending
// signed order. An element that finds its list already holding LIST_DEPTH entries is
// dropped and remembered as an overflow. end_of_list on a second-list element starts the
// merge; on a first-list element it has no effect.
// While merging, elem.ready is low. The result channel then delivers the sorted union
// with every distinct value once; union_last marks the final value and overflow_seen is
// set on every result of a round in which an element was dropped.
// The merge is set by the single read port of each list memory: every step reads both
// heads (S_READ) and then compares them (S_CMP), with at most first_count + second_count
// steps before the held value is flushed (S_FLUSH). The first result appears once a second
// distinct value is found or the lists run out, since each value is held back until the
// next one shows whether it is the last. A stalled receiver holds the result register and,
// once a further result is ready, the merge waits. Once the final value enters the result
// register, both lists are empty again.
// Reset empties both lists, clears the overflow mark and drops any pending result.

module sorted_list_merge_union_top #(
	parameter int LIST_DEPTH  = slmu_pkg::DEF_LIST_DEPTH,
	parameter int VALUE_WIDTH = slmu_pkg::DEF_VALUE_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	slmu_elem_if.sink     elem,
	slmu_union_if.source  result
);

	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

	typedef enum logic [3:0] {
		S_LOAD  = 4'b0001,
		S_READ  = 4'b0010,
		S_CMP   = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [CW-1:0]                 first_count_q;
	logic [CW-1:0]                 second_count_q;
	logic [CW-1:0]                 first_idx_q;
	logic [CW-1:0]                 second_idx_q;
	logic                          overflow_q;
	logic                          pend_valid_q;
	logic signed [VALUE_WIDTH-1:0] pend_q;
	logic signed [VALUE_WIDTH-1:0] first_rd_q;
	logic signed [VALUE_WIDTH-1:0] second_rd_q;
	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] out_value_q;
	logic                          out_last_q;
	logic                          out_ovf_q;

	logic signed [VALUE_WIDTH-1:0] first_mem  [LIST_DEPTH];
	logic signed [VALUE_WIDTH-1:0] second_mem [LIST_DEPTH];

	logic                          elem_fire;
	logic                          first_wr;
	logic                          second_wr;
	logic                          first_has;
	logic                          second_has;
	logic                          first_rd_en;
	logic                          second_rd_en;
	logic                          out_free;
	logic signed [VALUE_WIDTH-1:0] pick;
	logic                          adv_first;
	logic                          adv_second;
	logic                          is_new;
	logic                          cmp_go;
	logic                          emit_mid;
	logic                          emit_final;
	logic                          round_done;

	// Input handshake and store writes.
	assign elem.ready = (state_q == S_LOAD);
	assign elem_fire  = elem.valid && elem.ready;
	assign first_wr   = elem_fire && !elem.list_select && (first_count_q < DEPTH_C);
	assign second_wr  = elem_fire && elem.list_select && (second_count_q < DEPTH_C);

	// Merge head status and memory read enables.
	assign first_has    = first_idx_q < first_count_q;
	assign second_has   = second_idx_q < second_count_q;
	assign first_rd_en  = (state_q == S_READ) && first_has;
	assign second_rd_en = (state_q == S_READ) && second_has;

	assign out_free = !out_valid_q || result.ready;

	// Choose the smaller head, or the only head left, taking both when they are equal.
	always_comb begin
		pick       = first_rd_q;
		adv_first  = 1'b0;
		adv_second = 1'b0;
		if (!second_has) begin
			pick      = first_rd_q;
			adv_first = 1'b1;
		end else if (!first_has) begin
			pick       = second_rd_q;
			adv_second = 1'b1;
		end else if (first_rd_q == second_rd_q) begin
			pick       = first_rd_q;
			adv_first  = 1'b1;
			adv_second = 1'b1;
		end else if (first_rd_q < second_rd_q) begin
			pick      = first_rd_q;
			adv_first = 1'b1;
		end else begin
			pick       = second_rd_q;
			adv_second = 1'b1;
		end
	end

	// A new distinct value pushes the held value out; that needs a free output register.
	assign is_new     = !pend_valid_q || (pick != pend_q);
	assign cmp_go     = !(is_new && pend_valid_q) || out_free;
	assign emit_mid   = (state_q == S_CMP) && cmp_go && is_new && pend_valid_q;
	assign emit_final = (state_q == S_FLUSH) && pend_valid_q && out_free;
	assign round_done = (state_q == S_FLUSH) && (!pend_valid_q || out_free);

	// List memories: one write port while loading, one registered read port while merging.
	always_ff @(posedge clk) begin
		if (first_wr) begin
			first_mem[first_count_q[AW-1:0]] <= elem.element_value;
		end
		if (first_rd_en) begin
			first_rd_q <= first_mem[first_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (second_wr) begin
			second_mem[second_count_q[AW-1:0]] <= elem.element_value;
		end
		if (second_rd_en) begin
			second_rd_q <= second_mem[second_idx_q[AW-1:0]];
		end
	end

	// Sequencer, counts and overflow mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			first_count_q  <= '0;
			second_count_q <= '0;
			first_idx_q    <= '0;
			second_idx_q   <= '0;
			overflow_q     <= 1'b0;
			pend_valid_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (elem_fire) begin
						if (elem.list_select) begin
							if (second_wr) begin
								second_count_q <= second_count_q + CW'(1);
							end else begin
								overflow_q <= 1'b1;
							end
							if (elem.end_of_list) begin
								state_q <= S_READ;
							end
						end else begin
							if (first_wr) begin
								first_count_q <= first_count_q + CW'(1);
							end else begin
								overflow_q <= 1'b1;
							end
						end
					end
				end
				S_READ: begin
					if (first_has || second_has) begin
						state_q <= S_CMP;
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_CMP: begin
					if (cmp_go) begin
						if (adv_first) begin
							first_idx_q <= first_idx_q + CW'(1);
						end
						if (adv_second) begin
							second_idx_q <= second_idx_q + CW'(1);
						end
						if (is_new) begin
							pend_valid_q <= 1'b1;
						end
						state_q <= S_READ;
					end
				end
				S_FLUSH: begin
					if (round_done) begin
						first_count_q  <= '0;
						second_count_q <= '0;
						first_idx_q    <= '0;
						second_idx_q   <= '0;
						overflow_q     <= 1'b0;
						pend_valid_q   <= 1'b0;
						state_q        <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Held value: the latest distinct pick, not yet known to be last or not.
	always_ff @(posedge clk) begin
		if ((state_q == S_CMP) && cmp_go && is_new) begin
			pend_q <= pick;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_mid || emit_final) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit_mid || emit_final) begin
			out_value_q <= pend_q;
			out_last_q  <= emit_final;
			out_ovf_q   <= overflow_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.union_value   = out_value_q;
	assign result.union_last    = out_last_q;
	assign result.overflow_seen = out_ovf_q;

endmodule

FILE: bench/tb_sorted_list_merge_union_top.sv
// Self-checking bench for sorted_list_merge_union_top: drives list elements and checks
// every union value against a behavioural prediction of the merge.
// Depends on slmu_pkg, slmu_elem_if, slmu_union_if and the top level of the block.
`timescale 1ns / 1ps

module tb_sorted_list_merge_union_top;

	localparam int LD = slmu_pkg::DEF_LIST_DEPTH;
	localparam int VW = slmu_pkg::DEF_VALUE_WIDTH;
	localparam int RANDOM_ITEMS   = 230;
	localparam int MAX_WAIT       = 19;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 150;
	localparam int REPORT_LIMIT   = 10;

	typedef logic signed [VW-1:0] value_t;

	localparam value_t VALUE_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam value_t VALUE_MAX = {1'b0, {(VW-1){1'b1}}};

	// One value of the sorted union as the block should present it.
	typedef struct {
		value_t value;
		logic   last;
		logic   ovf;
	} union_t;

	// One row of the directed stimulus; a pinned row expects exactly one union value.
	typedef struct {
		bit     sel;
		value_t value;
		bit     eol;
		bit     pinned;
		value_t pin_value;
	} elem_row_t;

	// How the values of a random pair of lists are spread.
	typedef enum int {
		SPREAD_DENSE,
		SPREAD_WIDE,
		SPREAD_EXTREME,
		SPREAD_SCRAMBLED
	} spread_t;

	logic clk = 1'b0;
	logic arst_n;

	slmu_elem_if  #(.VALUE_WIDTH(VW)) elem_ch ();
	slmu_union_if #(.VALUE_WIDTH(VW)) result_ch ();

	sorted_list_merge_union_top #(
		.LIST_DEPTH  (LD),
		.VALUE_WIDTH (VW)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	// Predicted list contents and the union values still owed by the block.
	value_t    first_store [LD];
	value_t    second_store [LD];
	int        first_n;
	int        second_n;
	bit        dropped;
	union_t    merge_out [$];
	union_t    pending_union [$];
	elem_row_t directed [$];

	int errors;
	int elements_sent;
	int rounds_merged;
	int overflow_rounds;
	int values_checked;
	int idle_cycles;

	function automatic void flag_error(input string msg);
		errors++;
		if (errors <= REPORT_LIMIT) begin
			$display("ERROR: %s", msg);
		end
	endfunction

	// Store one accepted element; the end of the second list merges both lists into
	// merge_out and empties them for the next round.
	function automatic void take_element(input bit sel, input value_t v, input bit eol);
		int     i;
		int     j;
		value_t pick;
		value_t prev;
		bit     have_prev;
		union_t r;
		i = 0;
		j = 0;
		have_prev = 1'b0;
		prev = '0;
		merge_out.delete();
		if (sel == 1'b0) begin
			if (first_n < LD) begin
				first_store[first_n] = v;
				first_n++;
			end else begin
				dropped = 1'b1;
			end
			return;
		end
		if (second_n < LD) begin
			second_store[second_n] = v;
			second_n++;
		end else begin
			dropped = 1'b1;
		end
		if (!eol) begin
			return;
		end
		while (i < first_n || j < second_n) begin
			if (j >= second_n) begin
				pick = first_store[i];
				i++;
			end else if (i >= first_n) begin
				pick = second_store[j];
				j++;
			end else if (first_store[i] == second_store[j]) begin
				pick = first_store[i];
				i++;
				j++;
			end else if (first_store[i] < second_store[j]) begin
				pick = first_store[i];
				i++;
			end else begin
				pick = second_store[j];
				j++;
			end
			// A value equal to the one just emitted is skipped.
			if (!have_prev || pick != prev) begin
				r.value = pick;
				r.last  = 1'b0;
				r.ovf   = dropped;
				merge_out.push_back(r);
				prev = pick;
				have_prev = 1'b1;
			end
		end
		if (merge_out.size() > 0) begin
			r = merge_out.pop_back();
			r.last = 1'b1;
			merge_out.push_back(r);
		end
		first_n  = 0;
		second_n = 0;
		dropped  = 1'b0;
	endfunction

	function automatic void add_row(input bit sel, input value_t v, input bit eol,
			input bit pinned = 1'b0, input value_t pin_value = '0);
		elem_row_t row;
		row.sel       = sel;
		row.value     = v;
		row.eol       = eol;
		row.pinned    = pinned;
		row.pin_value = pin_value;
		directed.push_back(row);
	endfunction

	// Next value of a list: ascending spreads step upwards and saturate at the maximum.
	function automatic value_t next_value(input spread_t spread, inout longint cur);
		longint stepv;
		case (spread)
			SPREAD_DENSE: begin
				stepv = longint'($urandom_range(0, 2));
			end
			SPREAD_WIDE: begin
				stepv = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(0, 1 << 28));
			end
			SPREAD_EXTREME: begin
				stepv = longint'($urandom);
			end
			default: begin
				return value_t'($urandom);
			end
		endcase
		cur = cur + stepv;
		if (cur > longint'(VALUE_MAX)) begin
			cur = longint'(VALUE_MAX);
		end
		return value_t'(cur);
	endfunction

	// Present one request on the element channel, wait for it to be taken, then predict.
	task automatic send_element(input bit sel, input value_t v, input bit eol,
			input bit pinned, input value_t pin_value, input bit calm);
		int     gap;
		union_t r;
		gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			elem_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem_ch.valid         <= 1'b1;
		elem_ch.list_select   <= sel;
		elem_ch.element_value <= v;
		elem_ch.end_of_list   <= eol;
		do @(posedge clk); while (!elem_ch.ready);
		elements_sent++;
		take_element(sel, v, eol);
		if (sel && eol) begin
			rounds_merged++;
			if (merge_out.size() > 0 && merge_out[0].ovf) begin
				overflow_rounds++;
			end
		end
		if (pinned) begin
			r.value = pin_value;
			r.last  = 1'b1;
			r.ovf   = 1'b0;
			pending_union.push_back(r);
		end else begin
			foreach (merge_out[k]) begin
				pending_union.push_back(merge_out[k]);
			end
		end
	endtask

	// One random pair of lists, loaded in a random interleaving, second list's end last.
	task automatic run_random_round();
		value_t  first_q [$];
		value_t  second_q [$];
		int      n1;
		int      n2;
		spread_t spread;
		longint  start;
		longint  cur1;
		longint  cur2;
		bit      calm;
		bit      sel;
		bit      eol;
		value_t  v;
		if ($urandom_range(0, 9) == 0) begin
			n1 = $urandom_range(10, LD + 2);
			n2 = $urandom_range(10, LD + 2);
		end else begin
			n1 = $urandom_range(0, 6);
			n2 = $urandom_range(1, 6);
		end
		case ($urandom_range(0, 13))
			0, 1, 2, 3, 4, 5: spread = SPREAD_DENSE;
			6, 7, 8, 9:       spread = SPREAD_WIDE;
			10, 11:           spread = SPREAD_EXTREME;
			default:          spread = SPREAD_SCRAMBLED;
		endcase
		case (spread)
			SPREAD_DENSE:   start = longint'($urandom_range(0, 20)) - 10;
			SPREAD_EXTREME: start = longint'(VALUE_MIN);
			default:        start = longint'(value_t'($urandom));
		endcase
		cur1 = start;
		cur2 = start;
		for (int k = 0; k < n1; k++) begin
			first_q.push_back(next_value(spread, cur1));
		end
		for (int k = 0; k < n2; k++) begin
			second_q.push_back(next_value(spread, cur2));
		end
		calm = ($urandom_range(0, 4) == 0);
		while (first_q.size() > 0 || second_q.size() > 1) begin
			if (first_q.size() == 0) begin
				sel = 1'b1;
			end else if (second_q.size() == 1) begin
				sel = 1'b0;
			end else begin
				sel = 1'($urandom_range(0, 1));
			end
			if (sel) begin
				v = second_q.pop_front();
				eol = 1'b0;
			end else begin
				v = first_q.pop_front();
				// The mark on the first list has no effect, so it is also set at random.
				eol = (first_q.size() == 0) ? 1'($urandom_range(0, 1)) :
					($urandom_range(0, 7) == 0);
			end
			send_element(sel, v, eol, 1'b0, '0, calm);
		end
		send_element(1'b1, second_q.pop_front(), 1'b1, 1'b0, '0, calm);
	endtask

	// Receiver: stalls at random, and checks each accepted request against the oldest
	// outstanding prediction.
	initial begin
		int     stall;
		bit     calm_rx;
		union_t want;
		result_ch.ready <= 1'b0;
		calm_rx = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm_rx ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			values_checked++;
			if (pending_union.size() == 0) begin
				flag_error($sformatf("union value %0d arrived with nothing outstanding",
					result_ch.union_value));
			end else begin
				want = pending_union.pop_front();
				if (result_ch.union_value !== want.value || result_ch.union_last !== want.last ||
						result_ch.overflow_seen !== want.ovf) begin
					flag_error($sformatf({"union value %0d: expected %0d last %0b overflow %0b, ",
						"got %0d last %0b overflow %0b"}, values_checked, want.value,
						want.last, want.ovf, result_ch.union_value, result_ch.union_last,
						result_ch.overflow_seen));
				end
			end
			if (result_ch.union_last === 1'b1) begin
				calm_rx = ($urandom_range(0, 3) == 0);
			end
		end
	end

	// Watchdog: a long stretch with no request on either channel means the block hung.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((elem_ch.valid && elem_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: %0d union values still outstanding", pending_union.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Main sequence: reset, directed rows, random rounds, drain.
	initial begin
		errors          = 0;
		elements_sent   = 0;
		rounds_merged   = 0;
		overflow_rounds = 0;
		values_checked  = 0;
		idle_cycles     = 0;
		first_n         = 0;
		second_n        = 0;
		dropped         = 1'b0;
		arst_n                <= 1'b0;
		elem_ch.valid         <= 1'b0;
		elem_ch.list_select   <= 1'b0;
		elem_ch.element_value <= '0;
		elem_ch.end_of_list   <= 1'b0;

		// Straight after reset: a lone second-list element at each extreme.
		add_row(1'b1, VALUE_MIN, 1'b1, 1'b1, VALUE_MIN);
		add_row(1'b1, VALUE_MAX, 1'b1, 1'b1, VALUE_MAX);
		// Interleaved loading, extremes, a shared value and an end mark on the first list.
		add_row(1'b1, -1, 1'b0);
		add_row(1'b0, VALUE_MIN, 1'b0);
		add_row(1'b1, 0, 1'b0);
		add_row(1'b0, -1, 1'b1);
		add_row(1'b1, VALUE_MAX, 1'b1);
		// Duplicates inside each list and across the two collapse to one value.
		add_row(1'b0, 5, 1'b0);
		add_row(1'b0, 5, 1'b0);
		add_row(1'b1, 5, 1'b0);
		add_row(1'b1, 5, 1'b1, 1'b1, 5);
		// Lists out of order: the merge runs unchanged.
		add_row(1'b0, 10, 1'b0);
		add_row(1'b0, 2, 1'b0);
		add_row(1'b1, 10, 1'b1);
		// A full second list whose end mark is dropped but still starts the merge.
		for (int k = 0; k <= LD; k++) begin
			add_row(1'b1, value_t'(k * 1000 - 8000), k == LD);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) begin
			send_element(directed[k].sel, directed[k].value, directed[k].eol,
				directed[k].pinned, directed[k].pin_value, 1'($urandom_range(0, 1)));
		end
		while (elements_sent - directed.size() < RANDOM_ITEMS) begin
			run_random_round();
		end
		elem_ch.valid <= 1'b0;

		while (pending_union.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Loaded %0d list elements over %0d merges (%0d with dropped elements).",
			elements_sent, rounds_merged, overflow_rounds);
		$display("Checked %0d union values, %0d errors.", values_checked, errors);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sorted_list_merge_union_top.f
rtl/core/slmu_pkg.sv
rtl/core/slmu_elem_if.sv
rtl/core/slmu_union_if.sv
rtl/core/sorted_list_merge_union_top.sv
bench/tb_sorted_list_merge_union_top.sv
